FILE: rtl/tkst_pkg.sv
// Shared types and constants for the top-k score tracker.
// Holds the store geometry, entry and write-request types, and operation codes.
// No dependencies.
package tkst_pkg;

    localparam int CAPACITY = 20;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int SCORE_W  = 16;
    localparam int TAG_W    = 16;
    localparam int OP_W     = 2;

    localparam logic [OP_W-1:0] OP_OFFER = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [TAG_W-1:0]   tag;
    } t_entry;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        t_entry           data;
    } t_wr_req;

endpackage

FILE: rtl/tkst_store.sv
// Entry store of the top-k score tracker: one write port, one registered read port.
// Depends on tkst_pkg for the entry and write-request types.
module tkst_store (
    input  logic                      i_clk,
    input  tkst_pkg::t_wr_req         i_wr,
    input  logic [tkst_pkg::IDX_W-1:0] i_raddr,
    output tkst_pkg::t_entry          o_rdata
);

    tkst_pkg::t_entry r_mem [tkst_pkg::CAPACITY];
    tkst_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/top_k_score_tracker.sv
// Top-k score tracker: keeps the CAPACITY best (score, tag) candidates sorted by
// ascending score in a single-port-style store, walked by a small sequencer that
// reuses one compare-and-move step. An offer is accepted, then takes one read step and
// one compare-and-write step for every entry visited, and one final write step when
// the walk runs off the end of the store. A readout takes a read, a load and an
// output state per entry and holds while the result stalls; a clear is done on
// acceptance. Input transfers are refused (o_stall high) while the sequencer is
// busy. Ties are resolved by placing a new candidate after every entry with an
// equal score; a full store evicts its minimum when the candidate scores at least
// that minimum. A readout of an empty store gives one result marked not valid and
// last. Depends on tkst_pkg and tkst_store.
module top_k_score_tracker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [tkst_pkg::OP_W-1:0]     i_op,
    input  logic [tkst_pkg::SCORE_W-1:0]  i_cand_score,
    input  logic [tkst_pkg::TAG_W-1:0]    i_cand_tag,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [tkst_pkg::SCORE_W-1:0]  o_entry_score,
    output logic [tkst_pkg::TAG_W-1:0]    o_entry_tag,
    output logic                          o_entry_valid,
    output logic                          o_last_entry
);

    localparam int IDX_W = tkst_pkg::IDX_W;
    localparam int CNT_W = tkst_pkg::CNT_W;

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1;
    localparam logic [2:0] S_CMP   = 3'd2;
    localparam logic [2:0] S_PUT   = 3'd3;
    localparam logic [2:0] S_ORD   = 3'd4;
    localparam logic [2:0] S_OLOAD = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    // Offer modes: insert into a store with room, check the minimum of a full
    // store, and replace the minimum by walking the rest of the store upward.
    localparam logic [1:0] M_INS = 2'd0;
    localparam logic [1:0] M_CHK = 2'd1;
    localparam logic [1:0] M_REP = 2'd2;

    localparam logic [CNT_W-1:0] CNT_CAP  = CNT_W'(tkst_pkg::CAPACITY);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(tkst_pkg::CAPACITY - 1);

    logic [2:0]                   r_state, n_state;
    logic [1:0]                   r_mode, n_mode;
    logic [CNT_W-1:0]             r_count, n_count;
    logic [IDX_W-1:0]             r_idx, n_idx;
    logic [IDX_W-1:0]             r_put, n_put;
    tkst_pkg::t_entry             r_cand, n_cand;
    logic                         r_out_valid, n_out_valid;
    tkst_pkg::t_entry             r_out, n_out;
    logic                         r_out_ev, n_out_ev;
    logic                         r_out_last, n_out_last;

    tkst_pkg::t_wr_req            wr;
    tkst_pkg::t_entry             rdata;
    logic                         in_xfer;
    logic [CNT_W-1:0]             count_m1;
    logic                         cand_below;

    tkst_store u_store (
        .i_clk   (i_clk),
        .i_wr    (wr),
        .i_raddr (r_idx),
        .o_rdata (rdata)
    );

    assign in_xfer    = i_valid && !o_stall;
    assign count_m1   = r_count - CNT_W'(1);
    // The shared compare: does the stored entry outrank the candidate?
    assign cand_below = rdata.score > r_cand.score;

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_count     = r_count;
        n_idx       = r_idx;
        n_put       = r_put;
        n_cand      = r_cand;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_out_ev    = r_out_ev;
        n_out_last  = r_out_last;
        wr          = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_cand.score = i_cand_score;
                    n_cand.tag   = i_cand_tag;
                    priority if (i_op == tkst_pkg::OP_OFFER) begin
                        if (r_count == '0) begin
                            // Empty store: the candidate goes straight to the front.
                            wr.we        = 1'b1;
                            wr.addr      = '0;
                            wr.data.score = i_cand_score;
                            wr.data.tag   = i_cand_tag;
                            n_count      = CNT_W'(1);
                        end else if (r_count < CNT_CAP) begin
                            n_mode  = M_INS;
                            n_idx   = count_m1[IDX_W-1:0];
                            n_state = S_RD;
                        end else begin
                            n_mode  = M_CHK;
                            n_idx   = '0;
                            n_state = S_RD;
                        end
                    end else if (i_op == tkst_pkg::OP_READ) begin
                        if (r_count == '0) begin
                            n_out       = '0;
                            n_out_ev    = 1'b0;
                            n_out_last  = 1'b1;
                            n_out_valid = 1'b1;
                            n_state     = S_OUT;
                        end else begin
                            n_idx   = '0;
                            n_state = S_ORD;
                        end
                    end else if (i_op == tkst_pkg::OP_CLEAR) begin
                        n_count = '0;
                    end else begin
                        // Unused code: no change.
                        n_state = S_IDLE;
                    end
                end
            end

            S_RD: begin
                // Store read of r_idx is in flight.
                n_state = S_CMP;
            end

            S_CMP: begin
                unique case (r_mode)
                    M_INS: begin
                        // Walk down, moving larger entries up by one place.
                        if (cand_below) begin
                            wr.we   = 1'b1;
                            wr.addr = r_idx + IDX_W'(1);
                            wr.data = rdata;
                            if (r_idx == '0) begin
                                n_put   = '0;
                                n_state = S_PUT;
                            end else begin
                                n_idx   = r_idx - IDX_W'(1);
                                n_state = S_RD;
                            end
                        end else begin
                            wr.we   = 1'b1;
                            wr.addr = r_idx + IDX_W'(1);
                            wr.data = r_cand;
                            n_count = r_count + CNT_W'(1);
                            n_state = S_IDLE;
                        end
                    end
                    M_CHK: begin
                        if (cand_below) begin
                            // Candidate is below the minimum: dropped.
                            n_state = S_IDLE;
                        end else if (r_idx == IDX_LAST) begin
                            // Single-entry store: overwrite in place.
                            n_put   = '0;
                            n_state = S_PUT;
                        end else begin
                            n_mode  = M_REP;
                            n_idx   = IDX_W'(1);
                            n_state = S_RD;
                        end
                    end
                    M_REP: begin
                        // Walk up, moving entries not above the candidate down.
                        if (!cand_below) begin
                            wr.we   = 1'b1;
                            wr.addr = r_idx - IDX_W'(1);
                            wr.data = rdata;
                            if (r_idx == IDX_LAST) begin
                                n_put   = IDX_LAST;
                                n_state = S_PUT;
                            end else begin
                                n_idx   = r_idx + IDX_W'(1);
                                n_state = S_RD;
                            end
                        end else begin
                            wr.we   = 1'b1;
                            wr.addr = r_idx - IDX_W'(1);
                            wr.data = r_cand;
                            n_state = S_IDLE;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end

            S_PUT: begin
                wr.we   = 1'b1;
                wr.addr = r_put;
                wr.data = r_cand;
                if (r_mode == M_INS) begin
                    n_count = r_count + CNT_W'(1);
                end
                n_state = S_IDLE;
            end

            S_ORD: begin
                n_state = S_OLOAD;
            end

            S_OLOAD: begin
                n_out       = rdata;
                n_out_ev    = 1'b1;
                n_out_last  = (r_idx == count_m1[IDX_W-1:0]);
                n_out_valid = 1'b1;
                n_state     = S_OUT;
            end

            S_OUT: begin
                if (!i_stall) begin
                    n_out_valid = 1'b0;
                    if (r_out_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + IDX_W'(1);
                        n_state = S_ORD;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= M_INS;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
        r_put      <= n_put;
        r_cand     <= n_cand;
        r_out      <= n_out;
        r_out_ev   <= n_out_ev;
        r_out_last <= n_out_last;
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_entry_score = r_out.score;
    assign o_entry_tag   = r_out.tag;
    assign o_entry_valid = r_out_ev;
    assign o_last_entry  = r_out_last;

    // A result is only ever shown from the output state.
    a_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_state == S_OUT))
        else $error("result valid outside the output state");

    // The fill count never passes the capacity.
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_CAP)
        else $error("kept count exceeds capacity");

    // A readout of an empty store gives one invalid, last result next cycle.
    a_empty_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && (i_op == tkst_pkg::OP_READ) && (r_count == '0)) |=>
            (o_valid && !o_entry_valid && o_last_entry))
        else $error("empty readout malformed");

    // An accepted offer into an empty store leaves exactly one entry.
    a_first_offer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && (i_op == tkst_pkg::OP_OFFER) && (r_count == '0)) |=>
            (r_count == CNT_W'(1)))
        else $error("first offer not kept");

endmodule
